[sv/qfn_pkg.sv]
`timescale 1ns / 1ps
// qfn_pkg: fixed widths and payload types for the quad face normal block.
// No dependencies.
package qfn_pkg;

  localparam int unsigned FieldWidth = 16;
  localparam int unsigned OutWidth   = 16;

  typedef struct packed {
    logic signed [FieldWidth-1:0] first_x;
    logic signed [FieldWidth-1:0] first_y;
    logic signed [FieldWidth-1:0] first_z;
    logic signed [FieldWidth-1:0] second_x;
    logic signed [FieldWidth-1:0] second_y;
    logic signed [FieldWidth-1:0] second_z;
    logic signed [FieldWidth-1:0] fourth_x;
    logic signed [FieldWidth-1:0] fourth_y;
    logic signed [FieldWidth-1:0] fourth_z;
  } qfn_in_t;

  typedef struct packed {
    logic signed [OutWidth-1:0] normal_x;
    logic signed [OutWidth-1:0] normal_y;
    logic signed [OutWidth-1:0] normal_z;
    logic                       degenerate;
  } qfn_out_t;

endpackage

[sv/qfn_in_if.sv]
`timescale 1ns / 1ps
// qfn_in_if: valid/ready channel carrying three polygon corners.
// Depends on qfn_pkg.
interface qfn_in_if import qfn_pkg::*; ();
  logic    valid;
  logic    ready;
  qfn_in_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/qfn_out_if.sv]
`timescale 1ns / 1ps
// qfn_out_if: valid/ready channel carrying the unit normal.
// Depends on qfn_pkg.
interface qfn_out_if import qfn_pkg::*; ();
  logic     valid;
  logic     ready;
  qfn_out_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[sv/qfn_sqrt_stage.sv]
`timescale 1ns / 1ps
// qfn_sqrt_stage: one registered step of a restoring square root, one
// result bit per stage from two remainder bits. Depends on nothing.
module qfn_sqrt_stage #(
  parameter int unsigned RW = 8,    // remainder / root width
  parameter int unsigned PW = 8     // carried payload width
) (
  input  logic          clk_i,
  input  logic          en_i,
  input  logic [RW-1:0] rem_i,
  input  logic [RW-1:0] root_i,
  input  logic [1:0]    pair_i,
  input  logic [PW-1:0] pay_i,
  output logic [RW-1:0] rem_o,
  output logic [RW-1:0] root_o,
  output logic [PW-1:0] pay_o
);
  logic [RW+1:0] trial;
  logic [RW+1:0] cand;
  logic          fit;

  always_comb begin
    cand  = {rem_i, pair_i};
    trial = {root_i, 2'b01};
    fit   = cand >= trial;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o  <= fit ? RW'(cand - trial) : RW'(cand);
      root_o <= {root_i[RW-2:0], fit};
      pay_o  <= pay_i;
    end
  end
endmodule

[sv/qfn_div_stage.sv]
`timescale 1ns / 1ps
// qfn_div_stage: one registered step of restoring division for three
// numerators sharing a divisor. Depends on nothing.
module qfn_div_stage #(
  parameter int unsigned DW = 8,
  parameter int unsigned NW = 8,
  parameter int unsigned QW = 8,
  parameter int unsigned PW = 8
) (
  input  logic            clk_i,
  input  logic            en_i,
  input  logic [DW-1:0]   den_i,
  input  logic [3*DW-1:0] rem_i,
  input  logic [3*NW-1:0] num_i,
  input  logic [3*QW-1:0] quo_i,
  input  logic [PW-1:0]   pay_i,
  output logic [DW-1:0]   den_o,
  output logic [3*DW-1:0] rem_o,
  output logic [3*NW-1:0] num_o,
  output logic [3*QW-1:0] quo_o,
  output logic [PW-1:0]   pay_o
);
  logic [3*DW-1:0] rem_d;
  logic [3*NW-1:0] num_d;
  logic [3*QW-1:0] quo_d;

  always_comb begin
    logic [DW:0] r;
    for (int k = 0; k < 3; k++) begin
      r = {rem_i[k*DW +: DW], num_i[k*NW+NW-1]};
      num_d[k*NW +: NW] = {num_i[k*NW +: NW-1], 1'b0};
      if (r >= {1'b0, den_i}) begin
        r = r - {1'b0, den_i};
        quo_d[k*QW +: QW] = {quo_i[k*QW +: QW-1], 1'b1};
      end else begin
        quo_d[k*QW +: QW] = {quo_i[k*QW +: QW-1], 1'b0};
      end
      rem_d[k*DW +: DW] = r[DW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      den_o <= den_i;
      rem_o <= rem_d;
      num_o <= num_d;
      quo_o <= quo_d;
      pay_o <= pay_i;
    end
  end
endmodule

[sv/quad_face_normal.sv]
`timescale 1ns / 1ps
// quad_face_normal: top level, pipelined unit face normal.
// Depends on qfn_pkg, qfn_in_if, qfn_out_if, qfn_sqrt_stage, qfn_div_stage.
//
// Usage: in_ch carries vertex 0, vertex 1 and vertex 3 of a polygon; out_ch
// returns the Q(NORMAL_FRAC_BITS) unit normal and a degenerate flag, set
// when the cross product is zero (normal is then zero).
// Throughput: one transaction per cycle, sustained while out_ch.ready stays high.
// Stages in order: edges, products, cross product, squares, SW square-root
// stages (one per root bit; SW is half the width of the sum of squares),
// CW + NORMAL_FRAC_BITS divider stages (one per quotient bit; CW is the
// cross-product magnitude width), then the output register.
// The pipeline advances as a whole: when the receiver holds ready low and
// the output register is full, every stage holds and in_ch.ready falls.
// Valid bits travel with the data, so nothing is lost or repeated.
// Reset clears all valid bits; data registers are not reset.
module quad_face_normal import qfn_pkg::*; #(
  parameter int unsigned COORD_WIDTH      = 16,
  parameter int unsigned NORMAL_FRAC_BITS = 14
) (
  input logic clk_i,
  input logic rst_ni,
  qfn_in_if.sink    in_ch,
  qfn_out_if.source out_ch
);
  localparam int unsigned DW = COORD_WIDTH + 1;       // edge width
  localparam int unsigned PW = 2 * DW + 1;            // product width
  localparam int unsigned CW = PW - 1;                // cross magnitude width
  localparam int unsigned QW0 = 2 * CW + 2;           // sum of squares
  localparam int unsigned SQW = QW0 + (QW0 % 2);
  localparam int unsigned SW = SQW / 2;               // root width
  localparam int unsigned NW = CW + NORMAL_FRAC_BITS; // numerator width
  localparam int unsigned QW = NW;
  localparam int unsigned NST = 4 + SW + NW;          // pipeline stages
  localparam int unsigned RW = SW + 2;

  logic [NST:0] vld_q;
  logic         adv;

  assign adv         = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-1:0], in_ch.valid};
    end
  end

  // stage 1: edges
  logic signed [DW-1:0] ax_q, ay_q, az_q, bx_q, by_q, bz_q;
  function automatic logic signed [DW-1:0] sx(input logic [FieldWidth-1:0] v);
    return DW'(signed'(v[COORD_WIDTH-1:0]));
  endfunction
  always_ff @(posedge clk_i) begin
    if (adv) begin
      ax_q <= sx(in_ch.data.first_x) - sx(in_ch.data.second_x);
      ay_q <= sx(in_ch.data.first_y) - sx(in_ch.data.second_y);
      az_q <= sx(in_ch.data.first_z) - sx(in_ch.data.second_z);
      bx_q <= sx(in_ch.data.first_x) - sx(in_ch.data.fourth_x);
      by_q <= sx(in_ch.data.first_y) - sx(in_ch.data.fourth_y);
      bz_q <= sx(in_ch.data.first_z) - sx(in_ch.data.fourth_z);
    end
  end

  // stage 2: six products
  logic signed [PW-1:0] p_q [6];
  always_ff @(posedge clk_i) begin
    if (adv) begin
      p_q[0] <= PW'(ay_q * bz_q);
      p_q[1] <= PW'(az_q * by_q);
      p_q[2] <= PW'(az_q * bx_q);
      p_q[3] <= PW'(ax_q * bz_q);
      p_q[4] <= PW'(ax_q * by_q);
      p_q[5] <= PW'(ay_q * bx_q);
    end
  end

  // stage 3: cross product as sign and magnitude
  logic [CW-1:0] m_q [3];
  logic [2:0]    neg_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        logic signed [PW-1:0] c;
        c = p_q[2*k] - p_q[2*k+1];
        neg_q[k] <= c[PW-1];
        m_q[k]   <= c[PW-1] ? CW'(-c) : CW'(c);
      end
    end
  end

  // stage 4: squares, then the sum, formed combinationally at the first root stage input
  logic [2*CW-1:0] sq_q [3];
  logic [CW-1:0]   m4_q [3];
  logic [2:0]      neg4_q;
  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        sq_q[k] <= m_q[k] * m_q[k];
        m4_q[k] <= m_q[k];
      end
      neg4_q <= neg_q;
    end
  end

  localparam int unsigned CPW = 3 * CW + 3;
  logic [SQW-1:0] sum;
  assign sum = SQW'(sq_q[0]) + SQW'(sq_q[1]) + SQW'(sq_q[2]);

  // square root stages carry the sum (shifted two bits per stage)
  logic [RW-1:0]        srem [SW+1];
  logic [RW-1:0]        sroot[SW+1];
  logic [SQW+CPW-1:0]   spay [SW+1];
  assign srem[0]  = '0;
  assign sroot[0] = '0;
  assign spay[0]  = {sum, neg4_q, m4_q[2], m4_q[1], m4_q[0]};

  for (genvar g = 0; g < SW; g++) begin : g_sqrt
    logic [SQW+CPW-1:0] pay_sh;
    assign pay_sh = {spay[g][SQW+CPW-3:CPW], 2'b00, spay[g][CPW-1:0]};
    qfn_sqrt_stage #(.RW(RW), .PW(SQW+CPW)) u_sq (
      .clk_i (clk_i),
      .en_i  (adv),
      .rem_i (srem[g]),
      .root_i(sroot[g]),
      .pair_i(spay[g][SQW+CPW-1 -: 2]),
      .pay_i (pay_sh),
      .rem_o (srem[g+1]),
      .root_o(sroot[g+1]),
      .pay_o (spay[g+1])
    );
  end

  // division stages: numerator m << NORMAL_FRAC_BITS, divisor root
  logic [SW-1:0]   dden [NW+1];
  logic [3*SW-1:0] drem [NW+1];
  logic [3*NW-1:0] dnum [NW+1];
  logic [3*QW-1:0] dquo [NW+1];
  logic [2:0]      dpay [NW+1];
  logic [CPW-1:0]  sfin;
  assign sfin    = spay[SW][CPW-1:0];
  assign dden[0] = sroot[SW][SW-1:0];
  assign drem[0] = '0;
  assign dquo[0] = '0;
  assign dpay[0] = sfin[CPW-1 -: 3];
  for (genvar k = 0; k < 3; k++) begin : g_num
    assign dnum[0][k*NW +: NW] = {sfin[k*CW +: CW], NORMAL_FRAC_BITS'(0)};
  end

  for (genvar g = 0; g < NW; g++) begin : g_div
    qfn_div_stage #(.DW(SW), .NW(NW), .QW(QW), .PW(3)) u_dv (
      .clk_i(clk_i),
      .en_i (adv),
      .den_i(dden[g]),
      .rem_i(drem[g]),
      .num_i(dnum[g]),
      .quo_i(dquo[g]),
      .pay_i(dpay[g]),
      .den_o(dden[g+1]),
      .rem_o(drem[g+1]),
      .num_o(dnum[g+1]),
      .quo_o(dquo[g+1]),
      .pay_o(dpay[g+1])
    );
  end

  // output register: sign, saturation, degenerate
  localparam logic [QW-1:0] LimPos = QW'((1 << (OutWidth - 1)) - 1);
  localparam logic [QW-1:0] LimNeg = QW'(1 << (OutWidth - 1));
  qfn_out_t res_d, res_q;
  logic     degen;
  logic [OutWidth-1:0] comp [3];

  assign degen = (dden[NW] == '0);
  always_comb begin
    logic [QW-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = dquo[NW][k*QW +: QW];
      if (dpay[NW][k]) begin
        if (q > LimNeg) q = LimNeg;
        comp[k] = OutWidth'(-q);
      end else begin
        if (q > LimPos) q = LimPos;
        comp[k] = OutWidth'(q);
      end
    end
    res_d.normal_x   = degen ? '0 : comp[0];
    res_d.normal_y   = degen ? '0 : comp[1];
    res_d.normal_z   = degen ? '0 : comp[2];
    res_d.degenerate = degen;
  end

  always_ff @(posedge clk_i) begin
    if (adv) res_q <= res_d;
  end

  assign out_ch.valid = vld_q[NST];
  assign out_ch.data  = res_q;
endmodule

[sv/qfn_checker.sv]
`timescale 1ns / 1ps
// qfn_checker: port-level assertions for quad_face_normal, bound to it.
// Depends on qfn_pkg.
module qfn_checker import qfn_pkg::*; (
  input logic     clk_i,
  input logic     rst_ni,
  input logic     in_valid_i,
  input logic     in_ready_i,
  input logic     out_valid_i,
  input logic     out_ready_i,
  input qfn_out_t out_data_i
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result dropped or changed while stalled");

  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("input taken while output stalled");

  a_degen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_data_i.degenerate |->
      out_data_i.normal_x == '0 && out_data_i.normal_y == '0 &&
      out_data_i.normal_z == '0)
    else $error("degenerate result with nonzero normal");

  a_rst: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_i)
    else $error("valid result after reset");
endmodule

bind quad_face_normal qfn_checker u_qfn_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_ch.valid),
  .in_ready_i (in_ch.ready),
  .out_valid_i(out_ch.valid),
  .out_ready_i(out_ch.ready),
  .out_data_i (out_ch.data)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench: random and directed check of quad_face_normal against a local predictor.
// Depends on qfn_pkg, qfn_in_if, qfn_out_if and quad_face_normal.
module testbench;
  import qfn_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned Latency    = 88;

  logic clk_i;
  logic rst_ni;

  qfn_in_if  in_ch ();
  qfn_out_if out_ch ();

  quad_face_normal DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  qfn_in_t  pending_faces[$];
  qfn_out_t expected_normals[$];
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned calm_until;
  bit          hold_sender;
  bit          stimulus_done;

  // Exact predictor: cross product, integer root, truncating scaled division.
  function automatic qfn_out_t face_normal(qfn_in_t f);
    qfn_out_t r;
    logic signed [63:0] ax, ay, az, bx, by, bz;
    logic signed [63:0] c[3];
    logic [127:0] sum, root, bitv, trial;
    logic [127:0] q;
    ax = 64'(f.first_x) - 64'(f.second_x);
    ay = 64'(f.first_y) - 64'(f.second_y);
    az = 64'(f.first_z) - 64'(f.second_z);
    bx = 64'(f.first_x) - 64'(f.fourth_x);
    by = 64'(f.first_y) - 64'(f.fourth_y);
    bz = 64'(f.first_z) - 64'(f.fourth_z);
    c[0] = ay * bz - az * by;
    c[1] = az * bx - ax * bz;
    c[2] = ax * by - ay * bx;
    sum = 128'(c[0] * c[0]) + 128'(c[1] * c[1]) + 128'(c[2] * c[2]);
    root = '0;
    for (int i = 63; i >= 0; i--) begin
      bitv = 128'(1) << i;
      trial = root | bitv;
      if (trial * trial <= sum) root = trial;
    end
    r = '0;
    if (root == 0) begin
      r.degenerate = 1'b1;
      return r;
    end
    for (int k = 0; k < 3; k++) begin
      q = ((c[k] < 0 ? 128'(-c[k]) : 128'(c[k])) << 14) / root;
      if (c[k] < 0) begin
        if (q > 32768) q = 32768;
        q = -q;
      end else if (q > 32767) begin
        q = 32767;
      end
      case (k)
        0: r.normal_x = q[15:0];
        1: r.normal_y = q[15:0];
        default: r.normal_z = q[15:0];
      endcase
    end
    return r;
  endfunction

  function automatic logic [15:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'($signed($urandom_range(0, 64)) - 32);
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic qfn_in_t rand_face();
    qfn_in_t f;
    f.first_x = rand_coord();  f.first_y = rand_coord();  f.first_z = rand_coord();
    f.second_x = rand_coord(); f.second_y = rand_coord(); f.second_z = rand_coord();
    f.fourth_x = rand_coord(); f.fourth_y = rand_coord(); f.fourth_z = rand_coord();
    // occasionally make the corners collinear
    if ($urandom_range(0, 19) == 0) begin
      f.fourth_x = f.second_x; f.fourth_y = f.second_y; f.fourth_z = f.second_z;
    end
    return f;
  endfunction

  function automatic qfn_in_t make_face(int x0, int y0, int z0, int x1, int y1, int z1,
                                        int x3, int y3, int z3);
    qfn_in_t f;
    f.first_x = 16'(x0);  f.first_y = 16'(y0);  f.first_z = 16'(z0);
    f.second_x = 16'(x1); f.second_y = 16'(y1); f.second_z = 16'(z1);
    f.fourth_x = 16'(x3); f.fourth_y = 16'(y3); f.fourth_z = 16'(z3);
    return f;
  endfunction

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Directed faces, then random ones; the sender stops once midway to drain.
  initial begin
    hold_sender = 1'b0;
    stimulus_done = 1'b0;
    calm_until = 300 + $urandom_range(0, 200);
    pending_faces.push_back(make_face(0, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_faces.push_back(make_face(0, 0, 0, -1, 0, 0, 0, -1, 0));
    pending_faces.push_back(make_face(0, 0, 0, 0, -1, 0, 0, 0, -1));
    pending_faces.push_back(make_face(0, 0, 0, 0, 0, -1, -1, 0, 0));
    pending_faces.push_back(make_face(0, 0, 0, 1, 0, 0, 0, 1, 0));
    pending_faces.push_back(make_face(32767, 32767, 32767, -32768, 32767, -32768,
                                      32767, -32768, -32768));
    pending_faces.push_back(make_face(-32768, -32768, -32768, 32767, -32768, 32767,
                                      -32768, 32767, 32767));
    pending_faces.push_back(make_face(32767, -32768, 0, -32768, 32767, 0, 0, 0, 32767));
    pending_faces.push_back(make_face(5, 5, 5, 7, 7, 7, 9, 9, 9));
    pending_faces.push_back(make_face(1, 2, 3, 1, 2, 3, 4, 5, 6));
    pending_faces.push_back(make_face(-32768, -32768, -32768, -32768, -32768, -32768,
                                      -32768, -32768, -32768));
    pending_faces.push_back(make_face(0, 0, 0, 3, 4, 0, 1, 1, 1));
    pending_faces.push_back(make_face(0, 0, 0, -32768, 0, 0, 0, 0, 32767));
    pending_faces.push_back(make_face(100, -200, 300, -400, 500, -600, 700, -800, 1));
    repeat (500) pending_faces.push_back(rand_face());
    wait (pending_faces.size() == 0);
    hold_sender = 1'b1;
    wait (expected_normals.size() == 0);
    @(posedge clk_i);
    hold_sender = 1'b0;
    repeat (500) pending_faces.push_back(rand_face());
    wait (pending_faces.size() == 0);
    stimulus_done = 1'b1;
  end

  // Driver: the head of the queue is the transaction on the bus until accepted
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ch.valid <= 1'b0;
      in_ch.data  <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_normals.push_back(face_normal(in_ch.data));
        void'(pending_faces.pop_front());
      end
      if (in_ch.valid && !in_ch.ready) begin
        // hold the transaction until accepted
      end else if (pending_faces.size() > 0 && !hold_sender &&
                   (cycle_count < calm_until || $urandom_range(0, 99) >= 11)) begin
        in_ch.valid <= 1'b1;
        in_ch.data  <= pending_faces[0];
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Monitor and receiver stalls
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
      cycle_count  <= 0;
      error_count  <= 0;
    end else begin
      qfn_out_t    exp_r;
      int unsigned errs;
      errs = 0;
      cycle_count  <= cycle_count + 1;
      out_ch.ready <= (cycle_count < calm_until) || ($urandom_range(0, 99) >= 11);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_normals.size() == 0) begin
          $error("normal with no face outstanding");
          errs++;
        end else begin
          exp_r = expected_normals.pop_front();
          if (out_ch.data.normal_x !== exp_r.normal_x) begin
            $error("normal_x: expected %0d, got %0d", exp_r.normal_x, out_ch.data.normal_x);
            errs++;
          end
          if (out_ch.data.normal_y !== exp_r.normal_y) begin
            $error("normal_y: expected %0d, got %0d", exp_r.normal_y, out_ch.data.normal_y);
            errs++;
          end
          if (out_ch.data.normal_z !== exp_r.normal_z) begin
            $error("normal_z: expected %0d, got %0d", exp_r.normal_z, out_ch.data.normal_z);
            errs++;
          end
          if (out_ch.data.degenerate !== exp_r.degenerate) begin
            $error("degenerate: expected %0b, got %0b", exp_r.degenerate,
                   out_ch.data.degenerate);
            errs++;
          end
        end
      end
      error_count <= error_count + errs;
    end
  end

  // End of run
  initial begin
    fork
      begin
        wait (stimulus_done && !in_ch.valid && expected_normals.size() == 0);
        repeat (2 * Latency) @(posedge clk_i);
      end
      wait (cycle_count >= CycleLimit);
    join_any
    if (cycle_count < CycleLimit && error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
